// ===== design/mrs_pkg.sv =====
`default_nettype none
package mrs_pkg;

    localparam int NUM_REGS_DEFAULT      = 50;
    localparam int BUF_BYTES_DEFAULT     = 64;
    localparam int MAX_READ_REGS_DEFAULT = 29;
    localparam int MAX_RESULTS           = 64;
    localparam int MIN_FRAME             = 8;

    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [7:0]  SLAVE_ADDR_RST = 8'd21;
    localparam logic [7:0]  GAP_LIMIT_RST  = 8'd5;
    localparam logic [15:0] REG0_RST       = 16'd22881;
    localparam logic [7:0]  FUNC_READ      = 8'h03;
    localparam logic [7:0]  FUNC_WRITE     = 8'h06;
    localparam logic [8:0]  SILENCE_MAX    = 9'd511;

    localparam logic [1:0] CMD_BYTE   = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_LWRITE = 2'd2;

    localparam logic REG_SLAVE_ADDR = 1'b0;
    localparam logic REG_GAP_LIMIT  = 1'b1;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_LWRITE = 2'd2
    } item_kind_t;

    typedef struct packed {
        item_kind_t  kind;
        logic [7:0]  data;
        logic [5:0]  addr;
        logic [15:0] value;
    } mrs_item_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/mrs_ram.sv =====
`default_nettype none
module mrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ===== design/mrs_front.sv =====
`default_nettype none
module mrs_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        cmd,
    input  wire logic [7:0]        rx_byte,
    input  wire logic [5:0]        local_addr,
    input  wire logic [15:0]       local_value,
    input  wire logic              pop,
    output logic                   q_valid,
    output mrs_pkg::mrs_item_t     q_item
);
    import mrs_pkg::*;

    mrs_item_t  slot_reg [2];
    mrs_item_t  item;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       keep;
    logic       push;

    // classify; unused code is taken and dropped
    always_comb
    begin
        item.kind  = KIND_BYTE;
        item.data  = rx_byte;
        item.addr  = local_addr;
        item.value = local_value;
        keep       = 1'b1;
        case (cmd)
            CMD_BYTE:   item.kind = KIND_BYTE;
            CMD_TICK:   item.kind = KIND_TICK;
            CMD_LWRITE: item.kind = KIND_LWRITE;
            default:    keep = 1'b0;
        endcase
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule
`default_nettype wire

// ===== design/mrs_back.sv =====
`default_nettype none
module mrs_back #(
    parameter int NUM_REGS      = mrs_pkg::NUM_REGS_DEFAULT,
    parameter int BUF_BYTES     = mrs_pkg::BUF_BYTES_DEFAULT,
    parameter int MAX_READ_REGS = mrs_pkg::MAX_READ_REGS_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire mrs_pkg::mrs_item_t q_item,
    output logic                   q_pop,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [7:0]        cfg_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             tx_byte,
    output logic                   last,
    output logic                   write_seen,
    output logic [5:0]             write_addr,
    output logic [15:0]            write_value
);
    import mrs_pkg::*;

    localparam int IDXW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int BW   = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
    localparam int LW   = $clog2(BUF_BYTES + 1);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_FETCH    = 5'b00010,
        S_REPLY    = 5'b00100,
        S_ECHO_RD  = 5'b01000,
        S_ECHO_OUT = 5'b10000
    } state_t;

    state_t         state_reg, state_next;
    logic [7:0]     slave_reg, slave_next;
    logic [7:0]     gap_reg, gap_next;
    logic [LW-1:0]  len_reg, len_next;
    logic [8:0]     sil_reg, sil_next;
    logic [15:0]    crc_reg, crc_next;
    logic [7:0]     last_b_reg, last_b_next;
    logic [7:0]     prev_b_reg, prev_b_next;
    logic [7:0]     hdr_reg [6];
    logic [7:0]     hdr_next [6];
    logic [NUM_REGS-1:0] vld_reg, vld_next;
    logic [7:0]     idx_reg, idx_next;
    logic [7:0]     cnt_reg, cnt_next;
    logic [7:0]     bc_reg, bc_next;
    logic [IDXW-1:0] ptr_reg, ptr_next;
    logic [15:0]    txcrc_reg, txcrc_next;
    logic           stored_reg, stored_next;
    logic [5:0]     wa_reg, wa_next;
    logic [15:0]    wv_reg, wv_next;
    logic           ovalid_reg, ovalid_next;
    logic [7:0]     otx_reg, otx_next;
    logic           olast_reg, olast_next;
    logic           ows_reg, ows_next;
    logic [5:0]     owa_reg, owa_next;
    logic [15:0]    owv_reg, owv_next;

    logic            fr_we;
    logic [BW-1:0]   fr_waddr;
    logic [7:0]      fr_q;
    logic            st_we;
    logic [IDXW-1:0] st_waddr;
    logic [15:0]     st_wdata;
    logic [15:0]     st_q;

    logic            take;
    logic            gap_hit;
    logic [LW-1:0]   base_len, new_len;
    logic [15:0]     base_crc, new_crc;
    logic            can_store;
    logic [7:0]      new_last, new_prev;
    logic            pass;
    logic [15:0]     f_addr, f_arg;
    logic            rd_ok, wr_ok, lw_ok;
    logic [15:0]     lw_wide;
    logic            emit_ok;
    logic [15:0]     reg_val;
    logic [7:0]      rb;
    logic            r_data, r_last;

    mrs_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_frame_ram (
        .clk   (clk),
        .we    (fr_we),
        .waddr (fr_waddr),
        .wdata (q_item.data),
        .raddr (idx_reg[BW-1:0]),
        .rdata (fr_q)
    );

    mrs_ram #(.WIDTH(16), .DEPTH(NUM_REGS)) u_store_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (ptr_reg),
        .rdata (st_q)
    );

    assign take    = (state_reg == S_IDLE) && q_valid;
    assign q_pop   = take;
    assign emit_ok = !ovalid_reg || out_ready;

    // byte path: gap restart, append, crc, frame check
    always_comb
    begin
        gap_hit   = sil_reg > {1'b0, gap_reg};
        base_len  = gap_hit ? '0 : len_reg;
        base_crc  = gap_hit ? CRC_INIT : crc_reg;
        can_store = base_len < LW'(BUF_BYTES);
        new_len   = can_store ? base_len + LW'(1) : base_len;
        new_crc   = (can_store && (new_len >= LW'(3))) ? crc_feed(base_crc, prev_b_reg)
                                                       : base_crc;
        new_last  = can_store ? q_item.data : last_b_reg;
        new_prev  = can_store ? last_b_reg : prev_b_reg;
        pass      = (9'(new_len) >= 9'(MIN_FRAME)) && (hdr_reg[0] == slave_reg)
                    && (new_crc == {new_last, new_prev});
        f_addr    = {hdr_reg[2], hdr_reg[3]};
        f_arg     = {hdr_reg[4], hdr_reg[5]};
        rd_ok     = (17'(f_addr) + 17'(f_arg) <= 17'(NUM_REGS))
                    && (f_arg <= 16'(MAX_READ_REGS))
                    && (18'd5 + {1'b0, f_arg, 1'b0} <= 18'(MAX_RESULTS));
        wr_ok     = 17'(f_addr) < 17'(NUM_REGS);
        lw_wide   = 16'(q_item.addr);
        lw_ok     = 17'(lw_wide) < 17'(NUM_REGS);
    end

    // reply byte selection
    always_comb
    begin
        reg_val = vld_reg[ptr_reg] ? st_q : ((ptr_reg == '0) ? REG0_RST : 16'h0000);
        r_data  = (idx_reg >= 8'd3) && (idx_reg < cnt_reg);
        r_last  = idx_reg == (cnt_reg + 8'd1);
        if (idx_reg == 8'd0)
        begin
            rb = slave_reg;
        end
        else if (idx_reg == 8'd1)
        begin
            rb = FUNC_READ;
        end
        else if (idx_reg == 8'd2)
        begin
            rb = bc_reg;
        end
        else if (r_data)
        begin
            rb = idx_reg[0] ? reg_val[15:8] : reg_val[7:0];
        end
        else if (idx_reg == cnt_reg)
        begin
            rb = txcrc_reg[7:0];
        end
        else
        begin
            rb = txcrc_reg[15:8];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        slave_next  = slave_reg;
        gap_next    = gap_reg;
        len_next    = len_reg;
        sil_next    = sil_reg;
        crc_next    = crc_reg;
        last_b_next = last_b_reg;
        prev_b_next = prev_b_reg;
        hdr_next    = hdr_reg;
        vld_next    = vld_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        bc_next     = bc_reg;
        ptr_next    = ptr_reg;
        txcrc_next  = txcrc_reg;
        stored_next = stored_reg;
        wa_next     = wa_reg;
        wv_next     = wv_reg;
        ovalid_next = ovalid_reg && !out_ready;
        otx_next    = otx_reg;
        olast_next  = olast_reg;
        ows_next    = ows_reg;
        owa_next    = owa_reg;
        owv_next    = owv_reg;
        fr_we       = 1'b0;
        fr_waddr    = base_len[BW-1:0];
        st_we       = 1'b0;
        st_waddr    = lw_wide[IDXW-1:0];
        st_wdata    = q_item.value;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_SLAVE_ADDR: slave_next = cfg_data;
                REG_GAP_LIMIT:  gap_next = cfg_data;
                default:        slave_next = slave_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    case (q_item.kind)
                        KIND_TICK:
                        begin
                            if (sil_reg < SILENCE_MAX)
                            begin
                                sil_next = sil_reg + 9'd1;
                            end
                        end
                        KIND_LWRITE:
                        begin
                            if (lw_ok)
                            begin
                                st_we    = 1'b1;
                                vld_next[st_waddr] = 1'b1;
                            end
                        end
                        default:
                        begin
                            sil_next    = '0;
                            fr_we       = can_store;
                            len_next    = new_len;
                            crc_next    = new_crc;
                            last_b_next = new_last;
                            prev_b_next = new_prev;
                            if (can_store && (base_len < LW'(6)))
                            begin
                                hdr_next[base_len[2:0]] = q_item.data;
                            end
                            if (pass)
                            begin
                                len_next = '0;
                                crc_next = CRC_INIT;
                                idx_next = 8'd0;
                                if ((hdr_reg[1] == FUNC_READ) && rd_ok)
                                begin
                                    cnt_next   = 8'd3 + {f_arg[6:0], 1'b0};
                                    bc_next    = {f_arg[6:0], 1'b0};
                                    ptr_next   = f_addr[IDXW-1:0];
                                    txcrc_next = CRC_INIT;
                                    state_next = S_REPLY;
                                end
                                else if (hdr_reg[1] == FUNC_WRITE)
                                begin
                                    cnt_next    = (9'(new_len) > 9'(MAX_RESULTS))
                                                  ? 8'(MAX_RESULTS) : 8'(new_len);
                                    stored_next = wr_ok;
                                    wa_next     = f_addr[5:0];
                                    wv_next     = f_arg;
                                    if (wr_ok)
                                    begin
                                        st_we    = 1'b1;
                                        st_waddr = f_addr[IDXW-1:0];
                                        st_wdata = f_arg;
                                        vld_next[f_addr[IDXW-1:0]] = 1'b1;
                                    end
                                    state_next = S_ECHO_RD;
                                end
                            end
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                state_next = S_REPLY;
            end
            S_REPLY:
            begin
                if (emit_ok)
                begin
                    ovalid_next = 1'b1;
                    otx_next    = rb;
                    olast_next  = r_last;
                    ows_next    = 1'b0;
                    owa_next    = '0;
                    owv_next    = '0;
                    idx_next    = idx_reg + 8'd1;
                    if (idx_reg < cnt_reg)
                    begin
                        txcrc_next = crc_feed(txcrc_reg, rb);
                    end
                    if (r_data && !idx_reg[0])
                    begin
                        ptr_next = ptr_reg + IDXW'(1);
                        if ((idx_reg + 8'd1) < cnt_reg)
                        begin
                            state_next = S_FETCH;
                        end
                    end
                    if (r_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ECHO_RD:
            begin
                state_next = S_ECHO_OUT;
            end
            S_ECHO_OUT:
            begin
                if (emit_ok)
                begin
                    ovalid_next = 1'b1;
                    otx_next    = fr_q;
                    olast_next  = (idx_reg + 8'd1) == cnt_reg;
                    ows_next    = stored_reg && (idx_reg == 8'd0);
                    owa_next    = (stored_reg && (idx_reg == 8'd0)) ? wa_reg : 6'd0;
                    owv_next    = (stored_reg && (idx_reg == 8'd0)) ? wv_reg : 16'd0;
                    idx_next    = idx_reg + 8'd1;
                    state_next  = ((idx_reg + 8'd1) == cnt_reg) ? S_IDLE : S_ECHO_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        last_b_reg <= last_b_next;
        prev_b_reg <= prev_b_next;
        hdr_reg    <= hdr_next;
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        bc_reg     <= bc_next;
        ptr_reg    <= ptr_next;
        txcrc_reg  <= txcrc_next;
        stored_reg <= stored_next;
        wa_reg     <= wa_next;
        wv_reg     <= wv_next;
        otx_reg    <= otx_next;
        olast_reg  <= olast_next;
        ows_reg    <= ows_next;
        owa_reg    <= owa_next;
        owv_reg    <= owv_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            slave_reg  <= SLAVE_ADDR_RST;
            gap_reg    <= GAP_LIMIT_RST;
            len_reg    <= '0;
            sil_reg    <= '0;
            crc_reg    <= CRC_INIT;
            vld_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            slave_reg  <= slave_next;
            gap_reg    <= gap_next;
            len_reg    <= len_next;
            sil_reg    <= sil_next;
            crc_reg    <= crc_next;
            vld_reg    <= vld_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid   = ovalid_reg;
    assign tx_byte     = otx_reg;
    assign last        = olast_reg;
    assign write_seen  = ows_reg;
    assign write_addr  = owa_reg;
    assign write_value = owv_reg;
endmodule
`default_nettype wire

// ===== design/modbus_rtu_register_slave.sv =====
// channel   | handshake                    | payload
// ----------+------------------------------+-----------------------------------------
// in        | in_valid / in_ready          | cmd, rx_byte, local_addr, local_value
// out       | out_valid / out_ready        | tx_byte, last, write_seen, write_addr,
//           |                              | write_value
// cfg       | cfg_we (no wait)             | cfg_index, cfg_data
//
// the frame engine handles a tick, a local write or a byte that does not complete
// a frame without leaving its idle state; a two-entry queue in front takes words
// while it works; a read reply passes through a fetch state between registers for
// the registered store read, and an echo alternates a read state and an output
// state for each byte, set by the registered read of the frame buffer
// reset clears control state only; the frame buffer needs no clearing and the
// register store answers reset values through per-entry valid bits
// a stalled output word holds the engine, the queue keeps taking input until full
`default_nettype none
module modbus_rtu_register_slave #(
    parameter int NUM_REGS      = mrs_pkg::NUM_REGS_DEFAULT,
    parameter int BUF_BYTES     = mrs_pkg::BUF_BYTES_DEFAULT,
    parameter int MAX_READ_REGS = mrs_pkg::MAX_READ_REGS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  cmd,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [5:0]  local_addr,
    input  wire logic [15:0] local_value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       tx_byte,
    output logic             last,
    output logic             write_seen,
    output logic [5:0]       write_addr,
    output logic [15:0]      write_value,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import mrs_pkg::*;

    // queue between classification and the frame engine
    logic      q_valid;
    logic      q_pop;
    mrs_item_t q_item;

    // front: takes words, drops the unused command code, queues the rest
    mrs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .rx_byte     (rx_byte),
        .local_addr  (local_addr),
        .local_value (local_value),
        .pop         (q_pop),
        .q_valid     (q_valid),
        .q_item      (q_item)
    );

    // back: frame assembly, crc check, register store, reply and echo streaming
    mrs_back #(
        .NUM_REGS      (NUM_REGS),
        .BUF_BYTES     (BUF_BYTES),
        .MAX_READ_REGS (MAX_READ_REGS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tx_byte     (tx_byte),
        .last        (last),
        .write_seen  (write_seen),
        .write_addr  (write_addr),
        .write_value (write_value)
    );
endmodule
`default_nettype wire

// ===== design/mrs_checker.sv =====
`default_nettype none
module mrs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [7:0]  tx_byte,
    input wire logic        last,
    input wire logic        write_seen,
    input wire logic [5:0]  write_addr,
    input wire logic [15:0] write_value
);
    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(last))
        else $error("output word changed while stalled");

    // write report fields are zero unless a write is reported
    a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_seen |-> (write_addr == 6'd0) && (write_value == 16'd0))
        else $error("write fields set without write report");

    // a reported write opens an echo, so it never falls on the final byte
    a_write_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_seen |-> !last)
        else $error("write report on final byte");

    // a taken write report is not followed straight away by another write report
    a_seen_once: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && write_seen |=> !(out_valid && write_seen))
        else $error("write reported twice in a row");
endmodule

bind modbus_rtu_register_slave mrs_checker u_mrs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .tx_byte     (tx_byte),
    .last        (last),
    .write_seen  (write_seen),
    .write_addr  (write_addr),
    .write_value (write_value)
);
`default_nettype wire

// ===== sim/modbus_rtu_register_slave_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module modbus_rtu_register_slave_tb;
    import mrs_pkg::*;

    localparam int          N_REGS      = 50;
    localparam int          N_BUF       = 64;
    localparam int          READ_MAX    = 29;
    localparam int          QUIET_LIMIT = 5000;
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam logic [7:0]  FUNC_OTHER  = 8'h10;

    typedef struct {
        logic [7:0]  tx;
        logic        fin;
        logic        ws;
        logic [5:0]  wa;
        logic [15:0] wv;
    } reply_word_t;

    // slave predictor plus the queue of reply words still owed by the block
    class reply_board;
        logic [7:0]  station;
        logic [7:0]  gap;
        logic [7:0]  frame_q[N_BUF];
        int unsigned frame_len;
        int unsigned silence;
        logic [15:0] regs[N_REGS];
        logic [15:0] crc_run;
        reply_word_t owed[$];

        function new();
            station = SLAVE_ADDR_RST;
            gap = GAP_LIMIT_RST;
            frame_len = 0;
            silence = 0;
            crc_run = 16'hFFFF;
            foreach (regs[i]) regs[i] = '0;
            regs[0] = 16'd22881;
        endfunction

        static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            r = c ^ {8'h00, b};
            repeat (8) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
            return r;
        endfunction

        function void set_reg(logic idx, logic [7:0] val);
            if (idx == REG_SLAVE_ADDR) station = val;
            else gap = val;
        endfunction

        function void owe(logic [7:0] b, logic f, logic s, logic [5:0] a, logic [15:0] v);
            reply_word_t w;
            w.tx = b; w.fin = f; w.ws = s; w.wa = a; w.wv = v;
            owed.push_back(w);
        endfunction

        // one accepted input word
        function void note_word(logic [1:0] c, logic [7:0] b, logic [5:0] la,
                                logic [15:0] lv);
            logic [15:0] rcv, addr, arg, crc_tx;
            logic [7:0]  tx[$];
            logic        stored;
            if (c == CMD_TICK)
            begin
                if (silence < 511) silence++;
                return;
            end
            if (c == CMD_LWRITE)
            begin
                if (la < N_REGS) regs[la] = lv;
                return;
            end
            if (c != CMD_BYTE) return;
            if (silence > gap)
            begin
                frame_len = 0;
                crc_run = 16'hFFFF;
            end
            silence = 0;
            if (frame_len < N_BUF)
            begin
                frame_q[frame_len] = b;
                frame_len++;
                if (frame_len >= 3) crc_run = crc_step(crc_run, frame_q[frame_len - 3]);
            end
            if (frame_len < 8 || frame_q[0] != station) return;
            rcv = {frame_q[frame_len - 1], frame_q[frame_len - 2]};
            if (crc_run != rcv) return;
            addr = {frame_q[2], frame_q[3]};
            arg = {frame_q[4], frame_q[5]};
            if (frame_q[1] == FUNC_READ)
            begin
                if (int'(addr) + int'(arg) <= N_REGS && arg <= READ_MAX)
                begin
                    tx = {station, FUNC_READ, 8'(2 * arg)};
                    for (int i = 0; i < arg; i++)
                    begin
                        tx.push_back(regs[addr + i][15:8]);
                        tx.push_back(regs[addr + i][7:0]);
                    end
                    crc_tx = 16'hFFFF;
                    foreach (tx[i]) crc_tx = crc_step(crc_tx, tx[i]);
                    tx.push_back(crc_tx[7:0]);
                    tx.push_back(crc_tx[15:8]);
                    foreach (tx[i]) owe(tx[i], i == tx.size() - 1, 1'b0, '0, '0);
                end
            end
            else if (frame_q[1] == FUNC_WRITE)
            begin
                stored = addr < N_REGS;
                if (stored) regs[addr] = arg;
                for (int i = 0; i < frame_len; i++)
                    owe(frame_q[i], i == frame_len - 1, stored && i == 0,
                        (stored && i == 0) ? addr[5:0] : 6'd0,
                        (stored && i == 0) ? arg : 16'd0);
            end
            frame_len = 0;
            crc_run = 16'hFFFF;
        endfunction

        // returns an empty string when the word matches
        function string check_word(reply_word_t got);
            reply_word_t w;
            if (owed.size() == 0)
                return $sformatf("unexpected reply word %02h", got.tx);
            w = owed.pop_front();
            if (got.tx !== w.tx || got.fin !== w.fin || got.ws !== w.ws ||
                got.wa !== w.wa || got.wv !== w.wv)
                return $sformatf("got %02h/%0b/%0b/%0d/%04h, want %02h/%0b/%0b/%0d/%04h",
                                 got.tx, got.fin, got.ws, got.wa, got.wv,
                                 w.tx, w.fin, w.ws, w.wa, w.wv);
            return "";
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  cmd;
    logic [7:0]  rx_byte;
    logic [5:0]  local_addr;
    logic [15:0] local_value;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  tx_byte;
    logic        last;
    logic        write_seen;
    logic [5:0]  write_addr;
    logic [15:0] write_value;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_data;

    reply_board  board;
    int          errors;
    int          quiet_cycles;
    int          items_sent;
    int          burst_left;
    bit          no_gaps;
    logic [15:0] stall_pattern;
    bit          stall_off;

    modbus_rtu_register_slave DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .rx_byte(rx_byte), .local_addr(local_addr), .local_value(local_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .tx_byte(tx_byte), .last(last), .write_seen(write_seen),
        .write_addr(write_addr), .write_value(write_value),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic report_mismatch(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    // reply side: check every accepted word against the oldest owed one
    always @(posedge clk)
    begin
        reply_word_t got;
        string msg;
        if (rst_n && out_valid && out_ready)
        begin
            got.tx = tx_byte; got.fin = last; got.ws = write_seen;
            got.wa = write_addr; got.wv = write_value;
            msg = board.check_word(got);
            if (msg != "") report_mismatch(msg);
        end
    end

    // receiver stalls follow a rotating pattern, sometimes switched off
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
        begin
            stall_pattern <= 16'($urandom());
            stall_off <= ($urandom_range(0, 3) == 0);
        end
        else
            stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
        out_ready <= stall_off || stall_pattern[0];
    end

    // watchdog on cycles where neither channel moves a word
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog expired");
            $display("modbus_rtu_register_slave_tb failed");
            $finish;
        end
    end

    // one input word; the sender runs in bursts with random gaps between
    task automatic send_word(logic [1:0] c, logic [7:0] b, logic [5:0] la, logic [15:0] lv);
        int gap_len;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap_len = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap_len > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap_len) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd <= c;
        rx_byte <= b;
        local_addr <= la;
        local_value <= lv;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_word(c, b, la, lv);
        if (c != CMD_UNUSED) items_sent++;
        @(negedge clk);
    endtask

    task automatic send_byte(logic [7:0] b);
        send_word(CMD_BYTE, b, 6'($urandom()), 16'($urandom()));
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_word(CMD_TICK, 8'($urandom()), 6'($urandom()), 16'($urandom()));
    endtask

    // silence long enough that the next byte opens a fresh frame
    task automatic restart_frame();
        send_ticks(int'(board.gap) + 1);
    endtask

    // frame body plus crc, low byte first; bad_crc flips a crc bit
    task automatic send_frame(logic [7:0] station, logic [7:0] func, logic [15:0] a,
                              logic [15:0] v, int extra, bit bad_crc);
        logic [7:0]  body[$];
        logic [15:0] c;
        body = {station, func, a[15:8], a[7:0], v[15:8], v[7:0]};
        repeat (extra) body.push_back(8'($urandom()));
        c = 16'hFFFF;
        foreach (body[i]) c = reply_board::crc_step(c, body[i]);
        if (bad_crc) c ^= 16'(1 << $urandom_range(0, 15));
        body.push_back(c[7:0]);
        body.push_back(c[15:8]);
        foreach (body[i])
        begin
            // side traffic inside a frame that keeps the silence count within the gap limit
            case ($urandom_range(0, 19))
                0: send_word(CMD_LWRITE, 8'($urandom()), 6'($urandom()), 16'($urandom()));
                1: send_word(CMD_UNUSED, 8'($urandom()), 6'($urandom()), 16'($urandom()));
                2: if (board.gap > 0) send_ticks($urandom_range(1, board.gap));
                default: ;
            endcase
            send_byte(body[i]);
        end
    endtask

    task automatic write_cfg(logic idx, logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.set_reg(idx, val);
        @(negedge clk);
    endtask

    // all owed words out, then room for words still held in the input queue
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (board.owed.size() != 0) @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    // one random sequence, mostly well-formed frames with random content
    task automatic random_sequence();
        int          pick;
        logic [15:0] a;
        logic [15:0] n;
        pick = $urandom_range(0, 99);
        a = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, N_REGS - 1));
        n = 16'($urandom_range(0, 6));
        if (pick < 35)
        begin
            if ($urandom_range(0, 7) == 0) n = 16'($urandom_range(7, READ_MAX));
            if (int'(a) + int'(n) > N_REGS) a = 16'(N_REGS) - n;
            send_frame(board.station, FUNC_READ, a, n, 0, 0);
        end
        else if (pick < 60)
            send_frame(board.station, FUNC_WRITE, a, 16'($urandom()), 0, 0);
        else if (pick < 68)
        begin
            // past the store or past the read limit: frame eaten, no reply
            if ($urandom_range(0, 1))
                send_frame(board.station, FUNC_READ, 16'($urandom_range(30, N_REGS - 1)),
                           16'($urandom_range(21, READ_MAX)), 0, 0);
            else
                send_frame(board.station, FUNC_READ, 16'd0, 16'($urandom_range(30, 65535)),
                           0, 0);
        end
        else if (pick < 73)
            send_frame(board.station, FUNC_READ, a, 16'd0, 0, 0);
        else if (pick < 78)
            send_frame(board.station, FUNC_OTHER ^ 8'($urandom_range(0, 7)), a, n, 0, 0);
        else if (pick < 83)
            send_frame(board.station, 8'($urandom()), 16'($urandom()), 16'($urandom()),
                       $urandom_range(0, 6), 0);
        else if (pick < 88)
        begin
            send_frame(board.station ^ 8'(1 << $urandom_range(0, 7)), FUNC_WRITE, a,
                       16'($urandom()), 0, 0);
            restart_frame();
        end
        else if (pick < 93)
        begin
            send_frame(board.station, FUNC_WRITE, a, 16'($urandom()), 0, 1);
            restart_frame();
        end
        else if (pick < 97)
            // long echo, up to a full buffer
            send_frame(board.station, FUNC_WRITE, a, 16'($urandom()),
                       $urandom_range(1, N_BUF - 8), 0);
        else
        begin
            // overflow the buffer with noise, then start over
            repeat (N_BUF + $urandom_range(1, 8)) send_byte(8'($urandom()));
            restart_frame();
        end
        if ($urandom_range(0, 3) == 0) send_ticks($urandom_range(0, 3));
    endtask

    task automatic random_phase(int quota);
        int goal;
        no_gaps = ($urandom_range(0, 3) == 0);
        goal = items_sent + quota;
        while (items_sent < goal)
        begin
            if ($urandom_range(0, 9) == 0) no_gaps = !no_gaps;
            random_sequence();
        end
        drain();
    endtask

    initial
    begin
        board = new();
        errors = 0;
        items_sent = 0;
        burst_left = 0;
        no_gaps = 0;
        stall_pattern = 16'hB6D9;
        stall_off = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_BYTE;
        rx_byte = '0;
        local_addr = '0;
        local_value = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_SLAVE_ADDR;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset register contents, extreme write, local writes and ignored items
        send_frame(board.station, FUNC_READ, 16'd0, 16'd1, 0, 0);
        send_frame(board.station, FUNC_WRITE, 16'(N_REGS - 1), 16'hFFFF, 0, 0);
        send_word(CMD_LWRITE, 8'hFF, 6'h3F, 16'hFFFF);
        send_word(CMD_LWRITE, 8'h00, 6'd0, 16'h0000);
        send_word(CMD_UNUSED, 8'hFF, 6'h3F, 16'hFFFF);
        send_ticks(1);
        drain();

        random_phase(30);

        write_cfg(REG_SLAVE_ADDR, 8'h00);
        write_cfg(REG_GAP_LIMIT, 8'h00);
        random_phase(30);

        // widest station address, then the longest read reply
        write_cfg(REG_SLAVE_ADDR, 8'hFF);
        write_cfg(REG_GAP_LIMIT, 8'd12);
        restart_frame();
        send_frame(board.station, FUNC_READ, 16'(N_REGS - READ_MAX), 16'(READ_MAX), 0, 0);
        random_phase(20);

        write_cfg(REG_SLAVE_ADDR, 8'($urandom()));
        write_cfg(REG_GAP_LIMIT, 8'($urandom_range(1, 10)));
        random_phase(30);

        repeat (50) @(negedge clk);
        while (board.owed.size() != 0)
        begin
            report_mismatch($sformatf("reply word %02h never arrived", board.owed[0].tx));
            void'(board.owed.pop_front());
        end
        if (errors == 0)
            $display("modbus_rtu_register_slave_tb passed");
        else
            $display("modbus_rtu_register_slave_tb failed");
        $finish;
    end
endmodule
`default_nettype wire
